FILE: rtl/ath_pkg.sv
package ath_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;
    localparam int HASH_SHIFT = 33;
    localparam int ADDR_SHIFT = 4;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_REPLACE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] block_address;
        logic [31:0] block_size;
        logic [63:0] caller_address;
        logic [7:0]  object_class;
        logic [7:0]  object_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot_index;
        logic [63:0] sequence_number;
        logic [63:0] live_count;
        logic [63:0] live_bytes;
        logic [63:0] peak_count;
        logic [63:0] peak_bytes;
        logic [63:0] alloc_total;
        logic [63:0] free_total;
        logic [63:0] collision_total;
        logic [63:0] full_total;
        logic [63:0] unknown_free_total;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;        // clear one slot of the clearing pass
        logic load;       // capture input item
        logic hash_mul;   // register the hash partial products
        logic hash_fin;   // form the start slot
        logic rd;         // read the probe slot
        logic step;       // advance the probe
        logic wr_alloc;   // write the record at the probe slot
        logic wr_free;    // clear the active mark at the probe slot
        logic stat_peak;  // update peaks after an allocation
        logic[2:0] status;
        logic res_load;   // capture the result item
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ignore;
        logic kind;
        logic slot_active;
        logic addr_match;
        logic addr_zero;
        logic last_probe;
    } t_sts;

endpackage

FILE: rtl/ath_ctrl.sv
module ath_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ath_pkg::t_sts i_sts,
    output ath_pkg::t_cmd o_cmd
);
    import ath_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MUL, S_FIN, S_RD, S_CHK, S_PEAK, S_RES, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_status, n_status;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.last_probe) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.ignore) begin
                    n_status = ST_IGNORED;
                    n_state  = S_RES;
                end else begin
                    o_cmd.hash_mul = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.hash_fin = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.kind == KIND_ALLOC) begin
                    if (!i_sts.slot_active || i_sts.addr_match) begin
                        o_cmd.wr_alloc = 1'b1;
                        n_status = i_sts.slot_active ? ST_REPLACE : ST_NEW;
                        n_state  = S_PEAK;
                    end else begin
                        o_cmd.step = 1'b1;
                        if (i_sts.last_probe) begin
                            n_status = ST_FULL;
                            n_state  = S_RES;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end else begin
                    if (i_sts.slot_active && i_sts.addr_match) begin
                        o_cmd.wr_free = 1'b1;
                        n_status = ST_FREED;
                        n_state  = S_RES;
                    end else if ((!i_sts.slot_active && i_sts.addr_zero) ||
                                 i_sts.last_probe) begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_RES;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_PEAK: begin
                o_cmd.stat_peak = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                o_cmd.res_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
            r_status    <= ST_IGNORED;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT)
        else $error("output valid outside output state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result item dropped while stalled");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_alloc && o_cmd.wr_free))
        else $error("two writes in one cycle");

endmodule

FILE: rtl/ath_dp.sv
module ath_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_enable,
    input  ath_pkg::t_in_item i_in_item,
    input  ath_pkg::t_cmd     i_cmd,
    output ath_pkg::t_sts     o_sts,
    output ath_pkg::t_out_item o_out_item
);
    import ath_pkg::*;

    // Table stores. Addresses and active marks are zeroed by the clearing
    // pass after reset.
    logic [63:0] r_addr_mem [TABLE_ENTRIES];
    logic        r_act_mem [TABLE_ENTRIES];
    logic [31:0] r_size_mem [TABLE_ENTRIES];
    logic [63:0] r_caller_mem [TABLE_ENTRIES];
    logic [63:0] r_seq_mem [TABLE_ENTRIES];
    logic [15:0] r_ct_mem [TABLE_ENTRIES];

    t_in_item    r_item;
    logic        r_ignore;
    logic [63:0] r_pp_lo;
    logic [31:0] r_pp_mid;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0] r_rd_addr;
    logic [31:0] r_rd_size;
    logic        r_rd_act;
    logic [63:0] r_seq;
    logic [63:0] r_live_cnt, r_live_bytes, r_peak_cnt, r_peak_bytes;
    logic [63:0] r_alloc, r_free, r_coll, r_full, r_unknown;
    t_out_item   r_out;

    logic [63:0] w_x0, w_hx;
    logic [63:0] w_hx_lo, w_mult_lo;
    logic [63:0] w_prod;
    logic [63:0] w_fin;
    logic [63:0] w_lc_off, w_lb_off;

    assign w_x0 = r_item.block_address >> ADDR_SHIFT;
    assign w_hx = w_x0 ^ (w_x0 >> HASH_SHIFT);
    assign w_hx_lo   = {32'd0, w_hx[31:0]};
    assign w_mult_lo = {32'd0, HASH_MULT[31:0]};
    // Low 64 bits of the product from the registered partial products of the 32-bit halves.
    assign w_prod = r_pp_lo + {r_pp_mid, 32'd0};
    assign w_fin = w_prod ^ (w_prod >> HASH_SHIFT);

    // Counts after taking off the old record on replacement or free.
    assign w_lb_off = (r_live_bytes >= {32'd0, r_rd_size}) ?
                      r_live_bytes - {32'd0, r_rd_size} : r_live_bytes;
    assign w_lc_off = (r_live_cnt != 64'd0) ? r_live_cnt - 64'd1 : r_live_cnt;

    assign o_sts.ignore      = r_ignore;
    assign o_sts.kind        = r_item.kind;
    assign o_sts.slot_active = r_rd_act;
    assign o_sts.addr_match  = (r_rd_addr == r_item.block_address);
    assign o_sts.addr_zero   = (r_rd_addr == 64'd0);
    assign o_sts.last_probe  = (r_cnt == CNT_W'(TABLE_ENTRIES - 1));
    assign o_out_item = r_out;

    // Memory reads and writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_addr <= r_addr_mem[r_idx];
            r_rd_size <= r_size_mem[r_idx];
            r_rd_act  <= r_act_mem[r_idx];
        end
        if (i_cmd.clr) begin
            r_addr_mem[r_idx] <= 64'd0;
            r_act_mem[r_idx]  <= 1'b0;
        end
        if (i_cmd.wr_alloc) begin
            r_addr_mem[r_idx]   <= r_item.block_address;
            r_act_mem[r_idx]    <= 1'b1;
            r_size_mem[r_idx]   <= r_item.block_size;
            r_caller_mem[r_idx] <= r_item.caller_address;
            r_seq_mem[r_idx]    <= r_seq + 64'd1;
            r_ct_mem[r_idx]     <= {r_item.object_class, r_item.object_tag};
        end
        if (i_cmd.wr_free) r_act_mem[r_idx] <= 1'b0;
    end

    // Item capture and hash partial products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_item;
            r_ignore <= !i_enable || (i_in_item.block_address == 64'd0) ||
                        (i_in_item.kind == KIND_ALLOC && i_in_item.block_size == 32'd0);
        end
        if (i_cmd.hash_mul) begin
            r_pp_lo  <= w_hx_lo * w_mult_lo;
            r_pp_mid <= w_hx[63:32] * HASH_MULT[31:0] + w_hx[31:0] * HASH_MULT[63:32];
        end
    end

    // Probe and clearing pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else if (i_cmd.hash_fin) begin
            r_idx <= w_fin[IDX_W-1:0];
            r_cnt <= '0;
        end else if (i_cmd.step || i_cmd.clr) begin
            r_idx <= r_idx + IDX_W'(1);
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0; r_live_cnt <= '0; r_live_bytes <= '0;
            r_peak_cnt <= '0; r_peak_bytes <= '0; r_alloc <= '0;
            r_free <= '0; r_coll <= '0; r_full <= '0; r_unknown <= '0;
        end else begin
            if (i_cmd.wr_alloc) begin
                r_seq   <= r_seq + 64'd1;
                r_alloc <= r_alloc + 64'd1;
                if (r_rd_act) begin
                    r_live_cnt   <= w_lc_off + 64'd1;
                    r_live_bytes <= w_lb_off + {32'd0, r_item.block_size};
                end else begin
                    r_live_cnt   <= r_live_cnt + 64'd1;
                    r_live_bytes <= r_live_bytes + {32'd0, r_item.block_size};
                end
            end
            if (i_cmd.wr_free) begin
                r_free       <= r_free + 64'd1;
                r_live_cnt   <= w_lc_off;
                r_live_bytes <= w_lb_off;
            end
            if (i_cmd.step && r_item.kind == KIND_ALLOC) r_coll <= r_coll + 64'd1;
            if (i_cmd.res_load && i_cmd.status == ST_FULL) r_full <= r_full + 64'd1;
            if (i_cmd.res_load && i_cmd.status == ST_UNKNOWN)
                r_unknown <= r_unknown + 64'd1;
            if (i_cmd.stat_peak) begin
                if (r_live_cnt > r_peak_cnt) r_peak_cnt <= r_live_cnt;
                if (r_live_bytes > r_peak_bytes) r_peak_bytes <= r_live_bytes;
            end
        end
    end

    // Result item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status          <= i_cmd.status;
            r_out.slot_index      <= (i_cmd.status == ST_NEW || i_cmd.status == ST_REPLACE ||
                                      i_cmd.status == ST_FREED) ? 16'(r_idx) : 16'd0;
            r_out.sequence_number <= r_seq;
            r_out.live_count      <= r_live_cnt;
            r_out.live_bytes      <= r_live_bytes;
            r_out.peak_count      <= r_peak_cnt;
            r_out.peak_bytes      <= r_peak_bytes;
            r_out.alloc_total     <= r_alloc;
            r_out.free_total      <= r_free;
            r_out.collision_total <= r_coll;
            r_out.full_total      <= r_full + ((i_cmd.status == ST_FULL) ? 64'd1 : 64'd0);
            r_out.unknown_free_total <= r_unknown +
                                      ((i_cmd.status == ST_UNKNOWN) ? 64'd1 : 64'd0);
        end
    end

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stat_peak |=> (r_peak_cnt >= r_live_cnt && r_peak_bytes >= r_live_bytes))
        else $error("peak below live value");
    a_free_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_free |-> r_rd_act)
        else $error("free of inactive slot");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_cnt < CNT_W'(TABLE_ENTRIES))
        else $error("probe ran past table");

endmodule

FILE: rtl/allocation_tracking_hash_table_unit.sv
// Channel | Signals                          | Payload
// input   | i_in_valid / o_in_stall          | i_in_item  (t_in_item)
// output  | o_out_valid / i_out_stall        | o_out_item (t_out_item)
// config  | i_cfg_we / i_cfg_wdata           | tracking enable bit
//
// One item at a time: an accepted item is hashed, its probe reads and checks slots,
// an allocation that writes a record then updates the peaks, and the result is
// loaded and held until taken. An ignored item skips the hash and the probe.
// The probe loop reads and checks one slot at a time; a full table probes all 1024 slots.
// After reset a clearing pass over all 1024 slots zeroes the address and active
// stores while the input stalls; statistics clear at once.
// Input stall is high while an item is in work or its result waits.
module allocation_tracking_hash_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ath_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ath_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import ath_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic r_enable;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_enable <= 1'b0;
        else if (i_cfg_we) r_enable <= i_cfg_wdata;
    end

    ath_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    ath_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_enable(r_enable),
        .i_in_item(i_in_item), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_out_item(o_out_item)
    );

endmodule

FILE: sim/tb_allocation_tracking_hash_table_unit.sv
module tb_allocation_tracking_hash_table_unit;
    import ath_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    allocation_tracking_hash_table_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock with a period of 12 units.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Shadow copy of the tracking table and its statistics.
    logic [63:0] tbl_addr [TABLE_ENTRIES];
    logic        tbl_live [TABLE_ENTRIES];
    logic [31:0] tbl_size [TABLE_ENTRIES];
    logic [63:0] seq_ctr;
    logic [63:0] n_live, b_live, n_peak, b_peak;
    logic [63:0] n_alloc, n_free, n_coll, n_full, n_unknown;
    logic        track_on;

    t_out_item expected_results[$];
    int        error_count;
    int        results_seen;
    int        hold_off_cycles;
    int        burst_left;
    logic [63:0] recent_addr[$];

    function automatic logic [IDX_W-1:0] home_slot(logic [63:0] a);
        logic [63:0] x;
        x = a >> ADDR_SHIFT;
        x = x ^ (x >> HASH_SHIFT);
        x = x * HASH_MULT;
        x = x ^ (x >> HASH_SHIFT);
        return x[IDX_W-1:0];
    endfunction

    function automatic void remove_bytes(logic [31:0] sz);
        if (b_live >= {32'd0, sz}) b_live = b_live - {32'd0, sz};
        if (n_live != 0) n_live = n_live - 1;
    endfunction

    // Apply one item to the shadow table and queue its result.
    function automatic void predict_table_update(t_in_item it);
        t_out_item r;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] start;
        logic done;
        r = '0;
        r.status = ST_IGNORED;
        if (track_on && it.block_address != 0
                && (it.kind == KIND_FREE || it.block_size != 0)) begin
            start = home_slot(it.block_address);
            done = 1'b0;
            if (it.kind == KIND_ALLOC) begin
                r.status = ST_FULL;
                for (int i = 0; i < TABLE_ENTRIES && !done; i++) begin
                    idx = start + i[IDX_W-1:0];
                    if (!tbl_live[idx] || tbl_addr[idx] == it.block_address) begin
                        r.status = ST_NEW;
                        if (tbl_live[idx]) begin
                            r.status = ST_REPLACE;
                            remove_bytes(tbl_size[idx]);
                        end
                        seq_ctr = seq_ctr + 1;
                        tbl_addr[idx] = it.block_address;
                        tbl_size[idx] = it.block_size;
                        tbl_live[idx] = 1'b1;
                        n_alloc = n_alloc + 1;
                        n_live = n_live + 1;
                        b_live = b_live + {32'd0, it.block_size};
                        if (n_live > n_peak) n_peak = n_live;
                        if (b_live > b_peak) b_peak = b_live;
                        r.slot_index = 16'(idx);
                        done = 1'b1;
                    end else begin
                        n_coll = n_coll + 1;
                    end
                end
                if (!done) n_full = n_full + 1;
            end else begin
                r.status = ST_UNKNOWN;
                for (int i = 0; i < TABLE_ENTRIES && !done; i++) begin
                    idx = start + i[IDX_W-1:0];
                    if (tbl_live[idx] && tbl_addr[idx] == it.block_address) begin
                        tbl_live[idx] = 1'b0;
                        n_free = n_free + 1;
                        remove_bytes(tbl_size[idx]);
                        r.status = ST_FREED;
                        r.slot_index = 16'(idx);
                        done = 1'b1;
                    end else if (!tbl_live[idx] && tbl_addr[idx] == 0) begin
                        done = 1'b1;
                    end
                end
                if (r.status == ST_UNKNOWN) n_unknown = n_unknown + 1;
            end
        end
        r.sequence_number    = seq_ctr;
        r.live_count         = n_live;
        r.live_bytes         = b_live;
        r.peak_count         = n_peak;
        r.peak_bytes         = b_peak;
        r.alloc_total        = n_alloc;
        r.free_total         = n_free;
        r.collision_total    = n_coll;
        r.full_total         = n_full;
        r.unknown_free_total = n_unknown;
        expected_results.push_back(r);
    endfunction

    // Send one item, honoring the input stall; predict at acceptance.
    task automatic send_item(t_in_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_in_item  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_table_update(it);
        if (it.block_address != 0) recent_addr.push_back(it.block_address);
        if (recent_addr.size() > 64) void'(recent_addr.pop_front());
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_enable(logic en);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = en;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        track_on    = en;
    endtask

    function automatic t_in_item make_item(logic k, logic [63:0] a, logic [31:0] sz);
        t_in_item it;
        it.kind           = k;
        it.block_address  = a;
        it.block_size     = sz;
        it.caller_address = {$urandom, $urandom};
        it.object_class   = 8'($urandom);
        it.object_tag     = 8'($urandom);
        return it;
    endfunction

    // Receiver stall pattern plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (($urandom_range(0, 15) < 4) && results_seen % 50 < 35);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no expectation waiting");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_out_item.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out_item.status);
                    error_count++;
                end
                if (o_out_item.slot_index !== e.slot_index) begin
                    $error("slot_index exp %0d got %0d", e.slot_index,
                           o_out_item.slot_index);
                    error_count++;
                end
                if (o_out_item.sequence_number !== e.sequence_number) begin
                    $error("sequence_number exp %0h got %0h", e.sequence_number,
                           o_out_item.sequence_number);
                    error_count++;
                end
                if (o_out_item.live_count !== e.live_count) begin
                    $error("live_count exp %0h got %0h", e.live_count,
                           o_out_item.live_count);
                    error_count++;
                end
                if (o_out_item.live_bytes !== e.live_bytes) begin
                    $error("live_bytes exp %0h got %0h", e.live_bytes,
                           o_out_item.live_bytes);
                    error_count++;
                end
                if (o_out_item.peak_count !== e.peak_count) begin
                    $error("peak_count exp %0h got %0h", e.peak_count,
                           o_out_item.peak_count);
                    error_count++;
                end
                if (o_out_item.peak_bytes !== e.peak_bytes) begin
                    $error("peak_bytes exp %0h got %0h", e.peak_bytes,
                           o_out_item.peak_bytes);
                    error_count++;
                end
                if (o_out_item.alloc_total !== e.alloc_total) begin
                    $error("alloc_total exp %0h got %0h", e.alloc_total,
                           o_out_item.alloc_total);
                    error_count++;
                end
                if (o_out_item.free_total !== e.free_total) begin
                    $error("free_total exp %0h got %0h", e.free_total,
                           o_out_item.free_total);
                    error_count++;
                end
                if (o_out_item.collision_total !== e.collision_total) begin
                    $error("collision_total exp %0h got %0h", e.collision_total,
                           o_out_item.collision_total);
                    error_count++;
                end
                if (o_out_item.full_total !== e.full_total) begin
                    $error("full_total exp %0h got %0h", e.full_total,
                           o_out_item.full_total);
                    error_count++;
                end
                if (o_out_item.unknown_free_total !== e.unknown_free_total) begin
                    $error("unknown_free_total exp %0h got %0h", e.unknown_free_total,
                           o_out_item.unknown_free_total);
                    error_count++;
                end
            end
        end
    end

    // Disabled block, zero address and zero size are all ignored.
    task automatic test_ignored_items();
        send_item(make_item(KIND_ALLOC, 64'h1000, 32'd16));
        send_item(make_item(KIND_FREE, 64'h1000, 32'd0));
        write_enable(1'b1);
        send_item(make_item(KIND_ALLOC, 64'h0, 32'd8));
        send_item(make_item(KIND_FREE, 64'h0, 32'd0));
        send_item(make_item(KIND_ALLOC, 64'h2000, 32'd0));
    endtask

    // Field extremes, replacement, freeing, unknown free and live byte totals past 32 bits.
    task automatic test_directed_cases();
        t_in_item it;
        it = make_item(KIND_ALLOC, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        it.caller_address = '1;
        it.object_class   = 8'hff;
        it.object_tag     = 8'hff;
        send_item(it);
        it = make_item(KIND_ALLOC, 64'h1, 32'h1);
        it.caller_address = '0;
        it.object_class   = 8'h00;
        it.object_tag     = 8'h00;
        send_item(it);
        send_item(make_item(KIND_ALLOC, 64'h1, 32'd100));
        send_item(make_item(KIND_FREE, 64'h1, 32'hdead));
        send_item(make_item(KIND_FREE, 64'h1, 32'd0));
        send_item(make_item(KIND_FREE, 64'h8000_0000_0000_0000, 32'd0));
        send_item(make_item(KIND_ALLOC, 64'h1, 32'd7));
        send_item(make_item(KIND_ALLOC, 64'h10, 32'hffff_fff0));
        send_item(make_item(KIND_ALLOC, 64'h11, 32'hffff_fff0));
        send_item(make_item(KIND_FREE, 64'hffff_ffff_ffff_ffff, 32'd0));
        send_item(make_item(KIND_FREE, 64'h11, 32'd0));
        send_item(make_item(KIND_FREE, 64'h10, 32'd0));
    endtask

    // Mostly allocate/free pairs on a small address pool, some noise.
    task automatic test_random_traffic(int count);
        logic [63:0] a;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45 || recent_addr.size() == 0)
                a = {$urandom, $urandom} & {52'h0, 12'($urandom)} | 64'h0;
            else
                a = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
            if (sel >= 95) a = {$urandom, $urandom};
            if (sel == 94) a = 64'h0;
            send_item(make_item(1'($urandom_range(0, 99) < 40), a,
                      (sel == 93) ? 32'd0 : {$urandom} >> $urandom_range(0, 31)));
        end
    endtask

    // Long receiver hold-off while the sender keeps offering.
    task automatic test_backpressure();
        hold_off_cycles = 300;
        test_random_traffic(20);
        wait_drained();
        test_random_traffic(20);
    endtask

    // Allocate 96 blocks, then free, miss and reallocate, and send one item while disabled.
    task automatic test_dense_fill();
        for (int n = 0; n < 96; n++)
            send_item(make_item(KIND_ALLOC, 64'h10_0000 + 64'(n) * 16, 32'd4));
        send_item(make_item(KIND_ALLOC, 64'hdead_0000, 32'd4));
        send_item(make_item(KIND_FREE, 64'h10_0000, 32'd0));
        send_item(make_item(KIND_FREE, 64'hbeef_0000, 32'd0));
        send_item(make_item(KIND_ALLOC, 64'hdead_0000, 32'd4));
        write_enable(1'b0);
        send_item(make_item(KIND_ALLOC, 64'h4, 32'd4));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_out_stall = 1'b0;
        error_count = 0;
        results_seen = 0;
        hold_off_cycles = 0;
        burst_left = 0;
        track_on = 1'b0;
        seq_ctr = '0;
        {n_live, b_live, n_peak, b_peak} = '0;
        {n_alloc, n_free, n_coll, n_full, n_unknown} = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_addr[i] = '0;
            tbl_live[i] = 1'b0;
            tbl_size[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_ignored_items();
        test_directed_cases();
        test_random_traffic(150);
        write_enable(1'b0);
        test_random_traffic(15);
        write_enable(1'b1);
        test_backpressure();
        test_random_traffic(80);
        test_dense_fill();
        wait_drained();
        $display("Covered ignored items, replacement, frees, unknown frees, a dense fill,");
        $display("enable toggling and %0d checked results under stalls.", results_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS allocation_tracking_hash_table_unit");
        end else begin
            $display("FAIL allocation_tracking_hash_table_unit");
        end
        $finish;
    end

    // Watchdog sized for every item probing the whole table under stalls.
    initial begin
        #60000000;
        $display("FAIL allocation_tracking_hash_table_unit");
        $finish;
    end
endmodule
